// File: sv/sensor_node_table_tracker_core_assert.svh
// assertion macros for the station table tracker
`ifndef SENSOR_NODE_TABLE_TRACKER_CORE_ASSERT_SVH
`define SENSOR_NODE_TABLE_TRACKER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SNT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SNT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SNT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/snt_pkg.sv
// types and codes shared by the station table tracker
package snt_pkg;

    localparam logic [2:0] KIND_DATA    = 3'd0;
    localparam logic [2:0] KIND_REPLY   = 3'd1;
    localparam logic [2:0] KIND_TICK    = 3'd2;
    localparam logic [2:0] KIND_CMD     = 3'd3;
    localparam logic [2:0] KIND_LOST    = 3'd4;
    localparam logic [2:0] KIND_SLOT    = 3'd5;

    localparam logic [1:0] FST_OK       = 2'd0;
    localparam logic [1:0] FST_HEADER   = 2'd1;
    localparam logic [1:0] FST_FORMAT   = 2'd2;
    localparam logic [1:0] FST_CRC      = 2'd3;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_REJECT   = 2'd1;
    localparam logic [1:0] STS_FORMAT   = 2'd2;
    localparam logic [1:0] STS_CRC      = 2'd3;

    localparam logic [3:0] ATTR_STATUS  = 4'd0;
    localparam logic [3:0] ATTR_ACK     = 4'd1;
    localparam logic [3:0] ATTR_ERROR   = 4'd2;
    localparam logic [3:0] ATTR_HEALTH  = 4'd3;
    localparam logic [3:0] ATTR_VERSION = 4'd4;
    localparam logic [3:0] ATTR_TYPE    = 4'd5;
    localparam logic [3:0] ATTR_VOLTAGE = 4'd6;
    localparam logic [3:0] ATTR_TEMP    = 4'd7;
    localparam logic [3:0] ATTR_SENSOR  = 4'd8;

    typedef struct packed {
        logic [7:0] node_address;
        logic [7:0] stored_length;
        logic [7:0] node_kind;
        logic       node_synced;
        logic [7:0] awaited_op;
        logic [7:0] link_error_count;
        logic [7:0] firmware_version;
        logic [7:0] supply_voltage;
        logic [7:0] core_temperature;
        logic [7:0] sensor_fail_mask;
    } rec_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  station;
        logic [3:0]  attribute;
        logic [7:0]  value;
        logic [15:0] sample_index;
        logic [1:0]  frame_status;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  node_slot;
        logic [15:0] gap;
        logic [7:0]  slot_address;
        logic [7:0]  frame_length;
        logic [7:0]  awaited_ack;
        logic        all_lost;
    } result_t;

    typedef struct packed {
        logic rec;
        logic exp;
    } mem_wen_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SLOT,
        ST_EXEC,
        ST_CLEAR,
        ST_OUT
    } state_t;

endpackage

// File: sv/snt_mem.sv
// station record memory and expected index memory, one read port each cycle
module snt_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [IDX_W-1:0]       rd_addr,
    output snt_pkg::rec_t          rd_rec,
    output logic [15:0]            rd_exp,
    input  snt_pkg::mem_wen_t      wen,
    input  logic [IDX_W-1:0]       wr_addr,
    input  snt_pkg::rec_t          wr_rec,
    input  logic [15:0]            wr_exp
);
    import snt_pkg::*;

    rec_t        rec_mem [DEPTH];
    logic [15:0] exp_mem [DEPTH];
    rec_t        rd_rec_reg;
    logic [15:0] rd_exp_reg;

    always_ff @(posedge clk) begin
        if (wen.rec) begin
            rec_mem[wr_addr] <= wr_rec;
        end
        if (wen.exp) begin
            exp_mem[wr_addr] <= wr_exp;
        end
        if (rd_en) begin
            rd_rec_reg <= rec_mem[rd_addr];
            rd_exp_reg <= exp_mem[rd_addr];
        end
    end

    assign rd_rec = rd_rec_reg;
    assign rd_exp = rd_exp_reg;
endmodule

// File: sv/snt_ctrl.sv
// sequencer: address search, round-robin slot pick, read-modify-write of one record, expected index sweep
`include "sensor_node_table_tracker_core_assert.svh"
module snt_ctrl #(
    parameter int MAX_NODES = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  snt_pkg::item_t         item,
    output logic                   res_valid,
    input  logic                   res_free,
    output snt_pkg::result_t       res,
    output logic                   rd_en,
    output logic [IDX_W-1:0]       rd_addr,
    input  snt_pkg::rec_t          rd_rec,
    input  logic [15:0]            rd_exp,
    output snt_pkg::mem_wen_t      wen,
    output logic [IDX_W-1:0]       wr_addr,
    output snt_pkg::rec_t          wr_rec,
    output logic [15:0]            wr_exp
);
    import snt_pkg::*;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   sync_reg, sync_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    result_t            res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sync_reg      <= '0;
            ptr_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sync_reg      <= sync_next;
            ptr_reg       <= ptr_next;
            cmp_valid_reg <= cmp_valid_next;
        end
        item_reg    <= item_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
        hit_idx_reg <= hit_idx_next;
        res_reg     <= res_next;
    end

    always_comb begin
        rec_t             upd;
        logic             hitv;
        logic [IDX_W-1:0] ptr_w;
        state_next     = state_reg;
        item_next      = item_reg;
        cnt_next       = cnt_reg;
        sync_next      = sync_reg;
        ptr_next       = ptr_reg;
        issue_next     = issue_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        res_next       = res_reg;
        item_ready     = 1'b0;
        res_valid      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = issue_reg[IDX_W-1:0];
        wen            = '0;
        wr_addr        = hit_idx_reg;
        upd            = rd_rec;
        hitv           = hit_reg;
        wr_rec         = rd_rec;
        wr_exp         = '0;
        ptr_w          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item_valid) begin
                    item_next      = item;
                    issue_next     = '0;
                    cmp_valid_next = 1'b0;
                    hit_next       = 1'b0;
                    state_next     = (item.kind == KIND_SLOT) ? ST_SLOT : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // compare the word read last cycle while the next one is read
                if (cmp_valid_reg && rd_rec.node_address == item_reg.station) begin
                    hit_next       = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_EXEC;
                end else if (issue_reg < cnt_reg) begin
                    rd_en          = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                end else begin
                    hit_next       = 1'b0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_EXEC;
                end
            end
            ST_SLOT: begin
                if (cnt_reg == '0) begin
                    res_next        = '0;
                    res_next.status = STS_REJECT;
                    state_next      = ST_OUT;
                end else begin
                    ptr_w        = (CNT_W'(ptr_reg) >= cnt_reg) ? '0 : ptr_reg;
                    rd_en        = 1'b1;
                    rd_addr      = ptr_w;
                    ptr_next     = ptr_w;
                    hit_next     = 1'b1;
                    hit_idx_next = ptr_w;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next = '0;
                unique case (item_reg.kind)
                    KIND_DATA: begin
                        if (item_reg.frame_status == FST_HEADER) begin
                            res_next.status = STS_FORMAT;
                        end else if (!hit_reg) begin
                            res_next.status = STS_REJECT;
                        end else if (item_reg.frame_status == FST_FORMAT) begin
                            res_next.status = STS_FORMAT;
                        end else if (item_reg.frame_status == FST_CRC) begin
                            res_next.status = STS_CRC;
                        end else begin
                            upd.node_synced = 1'b1;
                            wen.rec         = 1'b1;
                            if (!rd_rec.node_synced) begin
                                sync_next = sync_reg + 1'b1;
                            end
                            if (item_reg.sample_index >= rd_exp) begin
                                res_next.gap = item_reg.sample_index - rd_exp;
                                wen.exp      = 1'b1;
                                wr_exp       = item_reg.sample_index + 16'd1;
                            end
                        end
                    end
                    KIND_REPLY: begin
                        if (item_reg.attribute == ATTR_STATUS) begin
                            if (hit_reg) begin
                                upd.stored_length  = item_reg.value;
                                wen.rec            = 1'b1;
                                res_next.node_slot = 4'(hit_idx_reg);
                            end else if (cnt_reg >= CNT_W'(MAX_NODES)) begin
                                res_next.status = STS_REJECT;
                            end else begin
                                // new station goes into the next free slot
                                upd                = '0;
                                upd.node_address   = item_reg.station;
                                upd.stored_length  = item_reg.value;
                                hitv               = 1'b1;
                                wr_addr            = cnt_reg[IDX_W-1:0];
                                wen.rec            = 1'b1;
                                wen.exp            = 1'b1;
                                cnt_next           = cnt_reg + 1'b1;
                                res_next.node_slot = 4'(cnt_reg[IDX_W-1:0]);
                            end
                        end else if (!hit_reg) begin
                            res_next.status = STS_REJECT;
                        end else begin
                            wen.rec = 1'b1;
                            unique case (item_reg.attribute)
                                ATTR_ACK: begin
                                    if (rd_rec.awaited_op == item_reg.value) begin
                                        upd.awaited_op = '0;
                                    end
                                end
                                ATTR_ERROR: begin
                                    upd.node_synced = 1'b0;
                                    if (rd_rec.node_synced) begin
                                        sync_next = sync_reg - 1'b1;
                                    end
                                end
                                ATTR_HEALTH:  upd.link_error_count = item_reg.value;
                                ATTR_VERSION: upd.firmware_version = item_reg.value;
                                ATTR_TYPE:    upd.node_kind        = item_reg.value;
                                ATTR_VOLTAGE: upd.supply_voltage   = item_reg.value;
                                ATTR_TEMP:    upd.core_temperature = item_reg.value;
                                ATTR_SENSOR:  upd.sensor_fail_mask = item_reg.value;
                                default:      wen.rec = 1'b0;
                            endcase
                        end
                    end
                    KIND_TICK: begin
                    end
                    KIND_CMD: begin
                        if (!hit_reg) begin
                            res_next.status = STS_REJECT;
                        end else begin
                            upd.awaited_op     = item_reg.value;
                            wen.rec            = 1'b1;
                            res_next.node_slot = 4'(hit_idx_reg);
                        end
                    end
                    KIND_LOST: begin
                        if (!hit_reg) begin
                            res_next.status = STS_REJECT;
                        end else begin
                            upd.node_synced    = 1'b0;
                            wen.rec            = 1'b1;
                            res_next.node_slot = 4'(hit_idx_reg);
                            if (rd_rec.node_synced) begin
                                sync_next = sync_reg - 1'b1;
                            end
                        end
                    end
                    KIND_SLOT: begin
                        res_next.slot_address = rd_rec.node_address;
                        ptr_next = (CNT_W'(ptr_reg) + 1'b1 == cnt_reg) ? '0 : ptr_reg + 1'b1;
                    end
                    default: begin
                        res_next.status = STS_REJECT;
                    end
                endcase
                wr_rec = upd;
                if (hitv) begin
                    res_next.frame_length = upd.stored_length;
                    res_next.awaited_ack  = upd.awaited_op;
                end
                res_next.all_lost = (cnt_next != '0) && (sync_next == '0);
                issue_next = '0;
                state_next = (item_reg.kind == KIND_TICK) ? ST_CLEAR : ST_OUT;
            end
            ST_CLEAR: begin
                // zero the expected index of every occupied slot
                if (issue_reg < cnt_reg) begin
                    wen.exp    = 1'b1;
                    wr_addr    = issue_reg[IDX_W-1:0];
                    issue_next = issue_reg + 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (res_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    `SNT_ASSERT_IMPL(a_sync_le_cnt, aclk, aresetn, 1'b1, sync_reg <= cnt_reg)
    `SNT_ASSERT_IMPL(a_cnt_le_max, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_NODES))
    `SNT_ASSERT_IMPL(a_cmp_in_table, aclk, aresetn, cmp_valid_reg, CNT_W'(cmp_idx_reg) < cnt_reg)
    `SNT_ASSERT_IMPL(a_ptr_in_table, aclk, aresetn, cnt_reg != '0, CNT_W'(ptr_reg) < cnt_reg)
    `SNT_ASSERT_NEXT(a_ready_idle, aclk, aresetn, item_valid && item_ready, state_reg != ST_IDLE)
endmodule

// File: sv/sensor_node_table_tracker_core.sv
// station table tracker top level: beat capture, result register, record memories
// throughput: one beat at a time; set by the one-word-per-cycle search of the record memory
// the result register lets the next beat enter while a result waits to be taken
// reset: synchronous active low, clears count, sync count and round-robin pointer
// record memories are not cleared; only slots below the count are ever read
`include "sensor_node_table_tracker_core_assert.svh"
module sensor_node_table_tracker_core #(
    parameter int MAX_NODES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic [7:0]  s_station,
    input  logic [3:0]  s_attribute,
    input  logic [7:0]  s_value,
    input  logic [15:0] s_sample_index,
    input  logic [1:0]  s_frame_status,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_node_slot,
    output logic [15:0] m_gap,
    output logic [7:0]  m_slot_address,
    output logic [7:0]  m_frame_length,
    output logic [7:0]  m_awaited_ack,
    output logic        m_all_lost
);
    import snt_pkg::*;

    localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    item_t            item;
    result_t          res;
    logic             res_valid;
    logic             res_free;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    rec_t             rd_rec;
    logic [15:0]      rd_exp;
    mem_wen_t         wen;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_rec;
    logic [15:0]      wr_exp;
    logic             m_valid_reg;
    result_t          m_res_reg;

    assign item = '{kind: s_kind, station: s_station, attribute: s_attribute,
                    value: s_value, sample_index: s_sample_index,
                    frame_status: s_frame_status};

    assign res_free = !m_valid_reg || m_ready;

    snt_ctrl #(
        .MAX_NODES(MAX_NODES),
        .IDX_W(IDX_W),
        .CNT_W(CNT_W)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .item_valid(s_valid),
        .item_ready(s_ready),
        .item(item),
        .res_valid(res_valid),
        .res_free(res_free),
        .res(res),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_rec(rd_rec),
        .rd_exp(rd_exp),
        .wen(wen),
        .wr_addr(wr_addr),
        .wr_rec(wr_rec),
        .wr_exp(wr_exp)
    );

    snt_mem #(
        .DEPTH(MAX_NODES),
        .IDX_W(IDX_W)
    ) u_mem (
        .clk(aclk),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .rd_rec(rd_rec),
        .rd_exp(rd_exp),
        .wen(wen),
        .wr_addr(wr_addr),
        .wr_rec(wr_rec),
        .wr_exp(wr_exp)
    );

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_res_reg.status;
    assign m_node_slot    = m_res_reg.node_slot;
    assign m_gap          = m_res_reg.gap;
    assign m_slot_address = m_res_reg.slot_address;
    assign m_frame_length = m_res_reg.frame_length;
    assign m_awaited_ack  = m_res_reg.awaited_ack;
    assign m_all_lost     = m_res_reg.all_lost;

    `SNT_ASSERT_IMPL(a_res_into_free, aclk, aresetn, res_valid, res_free)
    `SNT_ASSERT_NEXT(a_res_shown, aclk, aresetn, res_valid, m_valid_reg)
    `SNT_ASSERT_IMPL(a_no_accept_while_emit, aclk, aresetn, res_valid, !s_ready)
endmodule

// File: sim/tb_sensor_node_table_tracker_core.sv
// testbench for the station table tracker: queued driver, scoreboard monitor, table predictor
`timescale 1ns / 1ps
module tb_sensor_node_table_tracker_core;
    import snt_pkg::*;

    localparam int NODES = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_kind = '0;
    logic [7:0]  s_station = '0;
    logic [3:0]  s_attribute = '0;
    logic [7:0]  s_value = '0;
    logic [15:0] s_sample_index = '0;
    logic [1:0]  s_frame_status = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_node_slot;
    logic [15:0] m_gap;
    logic [7:0]  m_slot_address;
    logic [7:0]  m_frame_length;
    logic [7:0]  m_awaited_ack;
    logic        m_all_lost;

    sensor_node_table_tracker_core #(.MAX_NODES(NODES)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_station(s_station),
        .s_attribute(s_attribute), .s_value(s_value), .s_sample_index(s_sample_index),
        .s_frame_status(s_frame_status),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_node_slot(m_node_slot), .m_gap(m_gap), .m_slot_address(m_slot_address),
        .m_frame_length(m_frame_length), .m_awaited_ack(m_awaited_ack),
        .m_all_lost(m_all_lost)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow copy of the station table
    logic [7:0]  tab_addr [NODES];
    logic [7:0]  tab_len  [NODES];
    logic        tab_sync [NODES];
    logic [15:0] tab_next [NODES];
    logic [7:0]  tab_op   [NODES];
    int          tab_count = 0;
    int          rr_ptr = 0;

    item_t   beat_queue[$];
    result_t expected_results[$];
    int      n_bad = 0;

    function automatic int find_station(logic [7:0] a);
        for (int k = 0; k < tab_count; k++)
            if (tab_addr[k] == a) return k;
        return -1;
    endfunction

    function automatic result_t track_beat(item_t it);
        result_t r;
        int idx;
        logic [7:0] a;
        bit quiet;
        r = '0;
        a = it.station;
        case (it.kind)
            KIND_DATA: begin
                idx = find_station(a);
                if (it.frame_status == FST_HEADER) r.status = STS_FORMAT;
                else if (idx < 0) r.status = STS_REJECT;
                else if (it.frame_status == FST_FORMAT) r.status = STS_FORMAT;
                else if (it.frame_status == FST_CRC) r.status = STS_CRC;
                else begin
                    tab_sync[idx] = 1'b1;
                    if (it.sample_index >= tab_next[idx]) begin
                        r.gap = it.sample_index - tab_next[idx];
                        tab_next[idx] = it.sample_index + 16'd1;
                    end
                end
            end
            KIND_REPLY: begin
                idx = find_station(a);
                if (it.attribute == ATTR_STATUS) begin
                    if (idx >= 0) begin
                        tab_len[idx] = it.value;
                        r.node_slot = idx[3:0];
                    end else if (tab_count >= NODES) r.status = STS_REJECT;
                    else begin
                        tab_addr[tab_count] = a;
                        tab_len[tab_count] = it.value;
                        tab_sync[tab_count] = 1'b0;
                        tab_next[tab_count] = '0;
                        tab_op[tab_count] = '0;
                        r.node_slot = tab_count[3:0];
                        tab_count++;
                    end
                end else if (idx < 0) r.status = STS_REJECT;
                else if (it.attribute == ATTR_ACK) begin
                    if (tab_op[idx] == it.value) tab_op[idx] = '0;
                end else if (it.attribute == ATTR_ERROR) tab_sync[idx] = 1'b0;
            end
            KIND_TICK: for (int k = 0; k < tab_count; k++) tab_next[k] = '0;
            KIND_CMD, KIND_LOST: begin
                idx = find_station(a);
                if (idx < 0) r.status = STS_REJECT;
                else begin
                    if (it.kind == KIND_CMD) tab_op[idx] = it.value;
                    else tab_sync[idx] = 1'b0;
                    r.node_slot = idx[3:0];
                end
            end
            KIND_SLOT: begin
                if (tab_count == 0) r.status = STS_REJECT;
                else begin
                    if (rr_ptr >= tab_count) rr_ptr = 0;
                    r.slot_address = tab_addr[rr_ptr];
                    a = r.slot_address;
                    rr_ptr = (rr_ptr + 1) % tab_count;
                end
            end
            default: r.status = STS_REJECT;
        endcase
        idx = find_station(a);
        if (idx >= 0) begin
            r.frame_length = tab_len[idx];
            r.awaited_ack = tab_op[idx];
        end
        quiet = (tab_count != 0);
        for (int k = 0; k < tab_count; k++) if (tab_sync[k]) quiet = 1'b0;
        r.all_lost = quiet;
        return r;
    endfunction

    // driver: bursts with random gaps; the driven beat stays at the queue head until taken
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(track_beat(beat_queue.pop_front()));
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (beat_queue.size() > 0) begin
                    item_t nx;
                    nx = beat_queue[0];
                    s_valid <= 1'b1;
                    {s_kind, s_station, s_attribute, s_value, s_sample_index,
                     s_frame_status} <= nx;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else s_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern
    int rx_phase = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                result_t got, want;
                got = {m_status, m_node_slot, m_gap, m_slot_address, m_frame_length,
                       m_awaited_ack, m_all_lost};
                if (expected_results.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected result beat %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            rx_phase <= rx_phase + 1;
            if (rx_phase % 400 < 150) m_ready <= 1'b1;
            else if (rx_phase % 400 < 250) m_ready <= ($urandom_range(0, 7) != 0);
            else m_ready <= ($urandom_range(0, 2) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
        end
    end

    task automatic add_beat(logic [2:0] k, logic [7:0] st, logic [3:0] at, logic [7:0] v,
                            logic [15:0] si, logic [1:0] fs);
        item_t it;
        it = '{kind: k, station: st, attribute: at, value: v, sample_index: si,
               frame_status: fs};
        beat_queue.push_back(it);
    endtask

    initial begin
        logic [7:0] pool [24];
        int sel;
        logic [2:0] k;
        logic [1:0] fs;
        for (int p = 0; p < 24; p++) pool[p] = $urandom_range(0, 255);
        pool[0] = 8'h00;
        pool[1] = 8'hFF;
        // directed: empty table, registration, extremes, each special case
        add_beat(KIND_SLOT, 8'h00, 4'd0, 8'h00, 16'h0000, FST_OK);
        add_beat(KIND_DATA, 8'h55, 4'd0, 8'h00, 16'h0000, FST_HEADER);
        add_beat(KIND_DATA, 8'h55, 4'd0, 8'h00, 16'h0000, FST_OK);
        add_beat(KIND_REPLY, 8'h00, ATTR_STATUS, 8'hFF, 16'hFFFF, FST_OK);
        add_beat(KIND_REPLY, 8'hFF, ATTR_STATUS, 8'h00, 16'h0000, FST_CRC);
        add_beat(KIND_SLOT, 8'h00, 4'd0, 8'h00, 16'h0000, FST_OK);
        add_beat(KIND_DATA, 8'h00, 4'd0, 8'h00, 16'hFFFF, FST_OK);
        add_beat(KIND_DATA, 8'h00, 4'd0, 8'h00, 16'h0005, FST_OK);
        add_beat(KIND_DATA, 8'hFF, 4'd0, 8'h00, 16'h0010, FST_FORMAT);
        add_beat(KIND_DATA, 8'hFF, 4'd0, 8'h00, 16'h0010, FST_CRC);
        add_beat(KIND_DATA, 8'hFF, 4'd0, 8'h00, 16'h0010, FST_OK);
        add_beat(KIND_DATA, 8'hFF, 4'd0, 8'h00, 16'h0003, FST_OK);
        add_beat(KIND_CMD, 8'hFF, 4'd0, 8'hA5, 16'h0000, FST_OK);
        add_beat(KIND_REPLY, 8'hFF, ATTR_ACK, 8'h5A, 16'h0000, FST_OK);
        add_beat(KIND_REPLY, 8'hFF, ATTR_ACK, 8'hA5, 16'h0000, FST_OK);
        add_beat(KIND_REPLY, 8'hFF, ATTR_STATUS, 8'h42, 16'h0000, FST_OK);
        add_beat(KIND_REPLY, 8'h00, ATTR_ERROR, 8'h00, 16'h0000, FST_OK);
        add_beat(KIND_REPLY, 8'h00, 4'd15, 8'h11, 16'h0000, FST_OK);
        add_beat(KIND_REPLY, 8'h77, ATTR_TEMP, 8'h11, 16'h0000, FST_OK);
        add_beat(KIND_TICK, 8'h00, 4'd0, 8'h00, 16'h0000, FST_OK);
        add_beat(KIND_LOST, 8'hFF, 4'd0, 8'h00, 16'h0000, FST_OK);
        add_beat(KIND_LOST, 8'h77, 4'd0, 8'h00, 16'h0000, FST_OK);
        add_beat(3'd6, 8'h00, 4'd0, 8'h00, 16'h0000, FST_OK);
        add_beat(3'd7, 8'hFF, 4'hF, 8'hFF, 16'hFFFF, 2'd3);
        // random: mostly known stations, enough registrations to fill the table
        for (int n = 0; n < 1500; n++) begin
            sel = $urandom_range(0, 99);
            fs = ($urandom_range(0, 5) == 0) ? 2'($urandom_range(1, 3)) : FST_OK;
            if (sel < 20) k = KIND_REPLY;
            else if (sel < 50) k = KIND_DATA;
            else if (sel < 60) k = KIND_CMD;
            else if (sel < 66) k = KIND_LOST;
            else if (sel < 72) k = KIND_TICK;
            else if (sel < 96) k = KIND_SLOT;
            else k = 3'($urandom_range(6, 7));
            add_beat(k,
                     ($urandom_range(0, 9) == 0) ? 8'($urandom) : pool[$urandom_range(0, 23)],
                     ($urandom_range(0, 3) == 0) ? ATTR_STATUS : 4'($urandom),
                     ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                     ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                     fs);
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        wait (beat_queue.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge aclk);
        if (n_bad == 0 && expected_results.size() == 0) begin
            $display("PASS sensor_node_table_tracker_core");
        end else begin
            $display("FAIL sensor_node_table_tracker_core");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL sensor_node_table_tracker_core");
        $finish;
    end

endmodule
